### rtl/rsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types, widths and constants for the RGB saturation adjust pipeline.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int CompW  = 8;    // color component width
    localparam int GainW  = 12;   // Q4.8 gain
    localparam int FracW  = 16;   // fractional bits of hue and saturation
    localparam int QuoW   = FracW + 1;   // ratio in [0, 1.0]
    localparam int HueW   = FracW + 3;   // Q3.16, range [0, 6)

    localparam logic [QuoW-1:0]  ONE_Q16     = QuoW'(1) << FracW;
    localparam logic [GainW-1:0] GAIN_RESET  = GainW'(256);
    localparam logic [2:0]       SECTOR_WRAP = 3'd6;

    // input pixel as one transfer
    typedef struct packed {
        logic [CompW-1:0] red_in;
        logic [CompW-1:0] green_in;
        logic [CompW-1:0] blue_in;
        logic [CompW-1:0] alpha_in;
    } pix_in_t;

    // output pixel as one transfer
    typedef struct packed {
        logic [CompW-1:0] red_out;
        logic [CompW-1:0] green_out;
        logic [CompW-1:0] blue_out;
        logic [CompW-1:0] alpha_out;
    } pix_out_t;

    // partial state of the restoring divider
    typedef struct packed {
        logic [CompW-1:0] rem;
        logic [QuoW-1:0]  quo;
    } div_state_t;

    // one restoring step: shift remainder, trial subtract, shift in a bit
    function automatic div_state_t div_step(div_state_t st, logic [CompW-1:0] den);
        logic [CompW:0] t;
        div_state_t     nx;
        t = {st.rem, 1'b0};
        if (t >= {1'b0, den}) begin
            nx.rem = CompW'(t - {1'b0, den});
            nx.quo = {st.quo[QuoW-2:0], 1'b1};
        end else begin
            nx.rem = t[CompW-1:0];
            nx.quo = {st.quo[QuoW-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage
`default_nettype wire

### rtl/rgb_saturation_adjust.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_saturation_adjust
// Scales the HSV saturation of an RGBA8888 pixel stream by a Q4.8 gain.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry input pixels, m_valid/m_ready/m_data the
//   adjusted pixels; one result per input, in order. Alpha is copied.
//   cfg_valid/cfg_data write saturation_gain (Q4.8, 256 = unchanged);
//   cfg_ready is always high. Write it only while the pipeline is empty.
// Pipeline: six register stages (three divider stages, hue/gain stage,
//   multiply stage, output register).
// Throughput: one pixel per clock while m_ready stays high; the six-stage
//   pipeline with a valid bit per stage sets it.
// Stall: when m_ready is low, stages fill up behind the output register;
//   s_ready falls only once every stage holds a pixel. Nothing is dropped
//   or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets
//   the gain to 256.
// ----------------------------------------------------------------------------
module rgb_saturation_adjust
    import rsa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pix_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pix_out_t              m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [GainW-1:0] cfg_data
);

    localparam int NStg = 6;

    logic [GainW-1:0] gain_reg;
    logic [NStg:1]    vld_reg;
    logic [NStg+1:1]  rdy;

    // sideband through divider stages 1..3
    logic [CompW-1:0] mx_reg   [1:3];
    logic [CompW-1:0] al_reg   [1:3];
    logic [2:0]       base_reg [1:3];
    logic             neg_reg  [1:3];

    // front-end comb
    logic [CompW-1:0] mx, mn, dif, p, q, hnum, hden, sden;
    logic [2:0]       base;
    logic             neg;
    logic [QuoW-1:0]  hq, sq;

    // stage 4
    logic [HueW-1:0]  hue_reg, hue_next;
    logic [QuoW-1:0]  sg_reg, sg_next;
    logic [CompW-1:0] mx4_reg, al4_reg;

    // stage 5
    logic [QuoW+15:0] u_reg, u_next;
    logic [CompW-1:0] low_reg, low_next, mx5_reg, al5_reg;
    logic [2:0]       sec_reg, sec_next;

    // stage 6 (output)
    pix_out_t         out_reg, out_next;

    // ---- handshake: a stage moves when it is empty or the next one moves
    assign rdy[NStg+1] = m_ready;
    for (genvar i = 1; i <= NStg; i++) begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end
    assign s_ready   = rdy[1];
    assign m_valid   = vld_reg[NStg];
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            gain_reg <= GAIN_RESET;
        end else begin
            if (cfg_valid) begin
                gain_reg <= cfg_data;
            end
            if (rdy[1]) begin
                vld_reg[1] <= s_valid;
            end
            for (int i = 2; i <= NStg; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---- stage 1 front: max, min, hue numerator selection
    always_comb begin
        mx = s_data.red_in;
        mn = s_data.red_in;
        if (s_data.green_in > mx) mx = s_data.green_in;
        if (s_data.blue_in  > mx) mx = s_data.blue_in;
        if (s_data.green_in < mn) mn = s_data.green_in;
        if (s_data.blue_in  < mn) mn = s_data.blue_in;
        dif = mx - mn;
        if (mx == s_data.red_in) begin
            p = s_data.green_in; q = s_data.blue_in; base = 3'd0;
        end else if (mx == s_data.green_in) begin
            p = s_data.blue_in; q = s_data.red_in; base = 3'd2;
        end else begin
            p = s_data.red_in; q = s_data.green_in; base = 3'd4;
        end
        neg  = (p < q);
        hnum = neg ? CompW'(q - p) : CompW'(p - q);
        // zero divisor only with zero numerator: divide by one instead
        hden = (dif == '0) ? CompW'(1) : dif;
        sden = (mx == '0) ? CompW'(1) : mx;
    end

    rsa_div u_hue_div (
        .aclk (aclk),
        .en   (rdy[3:1]),
        .num  (hnum),
        .den  (hden),
        .quo  (hq)
    );

    rsa_div u_sat_div (
        .aclk (aclk),
        .en   (rdy[3:1]),
        .num  (dif),
        .den  (sden),
        .quo  (sq)
    );

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            mx_reg[1]   <= mx;
            al_reg[1]   <= s_data.alpha_in;
            base_reg[1] <= base;
            neg_reg[1]  <= neg;
        end
        for (int i = 2; i <= 3; i++) begin
            if (rdy[i]) begin
                mx_reg[i]   <= mx_reg[i-1];
                al_reg[i]   <= al_reg[i-1];
                base_reg[i] <= base_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
            end
        end
    end

    // ---- stage 4: hue assembly, saturation times gain with clamp
    always_comb begin
        logic [HueW-1:0]        pos;
        logic [QuoW+GainW-1:0]  prod;
        pos = HueW'(base_reg[3]) << FracW;
        if (neg_reg[3]) begin
            if (pos < HueW'(hq)) begin
                pos = pos + (HueW'(SECTOR_WRAP) << FracW);
            end
            hue_next = pos - HueW'(hq);
        end else begin
            hue_next = pos + HueW'(hq);
        end
        prod = (QuoW+GainW)'(sq) * (QuoW+GainW)'(gain_reg);
        if ((prod >> 8) > (QuoW+GainW)'(ONE_Q16)) begin
            sg_next = ONE_Q16;
        end else begin
            sg_next = prod[QuoW+7:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            hue_reg <= hue_next;
            sg_reg  <= sg_next;
            mx4_reg <= mx_reg[3];
            al4_reg <= al_reg[3];
        end
    end

    // ---- stage 5: ramp weight, low component, mid numerator
    always_comb begin
        logic [QuoW-1:0]       f, fdev, k, inv;
        logic [CompW+QuoW-1:0] lp;
        logic [2*QuoW-1:0]     sk;
        f    = hue_reg[QuoW-1:0];
        fdev = (f >= ONE_Q16) ? QuoW'(f - ONE_Q16) : QuoW'(ONE_Q16 - f);
        k    = ONE_Q16 - fdev;
        inv  = ONE_Q16 - sg_reg;
        lp   = (CompW+QuoW)'(mx4_reg) * (CompW+QuoW)'(inv);
        low_next = lp[CompW+FracW-1:FracW];
        sk   = (2*QuoW)'(sg_reg) * (2*QuoW)'(k);
        u_next = (QuoW+16)'(sk) + ((QuoW+16)'(inv) << FracW);
        sec_next = hue_reg[HueW-1:FracW];
        if (sec_next >= SECTOR_WRAP) begin
            sec_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            u_reg   <= u_next;
            low_reg <= low_next;
            sec_reg <= sec_next;
            mx5_reg <= mx4_reg;
            al5_reg <= al4_reg;
        end
    end

    // ---- stage 6: mid component and sector routing
    always_comb begin
        logic [CompW+QuoW+15:0] mp;
        logic [CompW-1:0]       mid, top, low;
        mp  = (CompW+QuoW+16)'(mx5_reg) * (CompW+QuoW+16)'(u_reg);
        mid = mp[CompW+2*FracW-1:2*FracW];
        top = mx5_reg;
        low = low_reg;
        out_next.alpha_out = al5_reg;
        case (sec_reg)
            3'd0: begin
                out_next.red_out = top; out_next.green_out = mid; out_next.blue_out = low;
            end
            3'd1: begin
                out_next.red_out = mid; out_next.green_out = top; out_next.blue_out = low;
            end
            3'd2: begin
                out_next.red_out = low; out_next.green_out = top; out_next.blue_out = mid;
            end
            3'd3: begin
                out_next.red_out = low; out_next.green_out = mid; out_next.blue_out = top;
            end
            3'd4: begin
                out_next.red_out = mid; out_next.green_out = low; out_next.blue_out = top;
            end
            default: begin
                out_next.red_out = top; out_next.green_out = low; out_next.blue_out = mid;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            out_reg <= out_next;
        end
    end

    // ---- checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("pipeline not empty after reset");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&vld_reg)))
        else $error("input stalled without full pipeline and output stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[1])
        else $error("accepted pixel lost at stage 1");

    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] |-> (sec_reg < SECTOR_WRAP))
        else $error("sector index out of range");

endmodule
`default_nettype wire

### rtl/rsa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_div
// Three-stage pipelined restoring divider: quo = floor(num * 2^16 / den),
// for num <= den and den > 0. Four, six and six steps per stage.
// ----------------------------------------------------------------------------
module rsa_div
    import rsa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic [2:0]       en,
    input  wire logic [CompW-1:0] num,
    input  wire logic [CompW-1:0] den,
    output logic      [QuoW-1:0]  quo
);

    div_state_t       st_a_reg, st_b_reg, st_c_reg;
    div_state_t       st_a_next, st_b_next, st_c_next;
    logic [CompW-1:0] den_a_reg, den_b_reg;

    // stage A: integer bit, then four fraction bits
    always_comb begin
        logic q16;
        q16 = (num >= den);
        st_a_next.rem = q16 ? CompW'(num - den) : num;
        st_a_next.quo = QuoW'(q16);
        for (int i = 0; i < 4; i++) begin
            st_a_next = div_step(st_a_next, den);
        end
    end

    // stage B: six fraction bits
    always_comb begin
        st_b_next = st_a_reg;
        for (int i = 0; i < 6; i++) begin
            st_b_next = div_step(st_b_next, den_a_reg);
        end
    end

    // stage C: last six fraction bits
    always_comb begin
        st_c_next = st_b_reg;
        for (int i = 0; i < 6; i++) begin
            st_c_next = div_step(st_c_next, den_b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            st_a_reg  <= st_a_next;
            den_a_reg <= den;
        end
        if (en[1]) begin
            st_b_reg  <= st_b_next;
            den_b_reg <= den_a_reg;
        end
        if (en[2]) begin
            st_c_reg  <= st_c_next;
        end
    end

    assign quo = st_c_reg.quo;

endmodule
`default_nettype wire

### sim/rgb_saturation_adjust_test.sv
// ----------------------------------------------------------------------------
// rgb_saturation_adjust_test
// Drives random and directed RGBA pixels through the saturation adjust block
// over several gain settings and checks every output pixel against a
// fixed-point HSV model kept in the bench.
// ----------------------------------------------------------------------------
module rgb_saturation_adjust_test
    import rsa_pkg::*;
();

    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 400000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    pix_in_t          s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    pix_out_t         m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [GainW-1:0] cfg_data = '0;

    pix_in_t          pending_pixels[$];
    pix_out_t         expected_pixels[$];
    logic [GainW-1:0] model_gain = GAIN_RESET;
    logic             quiet = 1'b0;     // no idling near the end
    int               src_idle = 0;
    int               snk_idle = 0;
    int               errors = 0;
    int               cycles = 0;

    rgb_saturation_adjust u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // fixed-point HSV saturation gain on one pixel
    function automatic pix_out_t saturate_pixel(pix_in_t px, logic [GainW-1:0] gain);
        logic [31:0] r, g, b, mx, mn, d, p, q, base, hue, mag, pos, s, f, fdev, sector;
        logic [63:0] sg, k, inv, top, low, mid;
        pix_out_t    o;
        r = px.red_in; g = px.green_in; b = px.blue_in;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hue = 0;
        if (d > 0) begin
            if (mx == r) begin
                p = g; q = b; base = 0;
            end else if (mx == g) begin
                p = b; q = r; base = 2;
            end else begin
                p = r; q = g; base = 4;
            end
            if (p >= q) begin
                hue = (base << 16) + ((p - q) << 16) / d;
            end else begin
                mag = ((q - p) << 16) / d;
                pos = base << 16;
                if (pos < mag) pos += 6 << 16;
                hue = pos - mag;
            end
        end
        s = (mx == 0) ? 0 : (d << 16) / mx;
        sg = (64'(s) * gain) >> 8;
        if (sg > 65536) sg = 65536;
        f = hue % (2 << 16);
        fdev = (f >= 65536) ? f - 65536 : 65536 - f;
        k = 65536 - fdev;
        inv = 65536 - sg;
        top = mx;
        low = (64'(mx) * inv) >> 16;
        mid = (64'(mx) * sg * k + ((64'(mx) * inv) << 16)) >> 32;
        sector = hue >> 16;
        if (sector >= 6) sector = 0;
        case (sector)
            0: begin o.red_out = top[7:0]; o.green_out = mid[7:0]; o.blue_out = low[7:0]; end
            1: begin o.red_out = mid[7:0]; o.green_out = top[7:0]; o.blue_out = low[7:0]; end
            2: begin o.red_out = low[7:0]; o.green_out = top[7:0]; o.blue_out = mid[7:0]; end
            3: begin o.red_out = low[7:0]; o.green_out = mid[7:0]; o.blue_out = top[7:0]; end
            4: begin o.red_out = mid[7:0]; o.green_out = low[7:0]; o.blue_out = top[7:0]; end
            default: begin
                o.red_out = top[7:0]; o.green_out = low[7:0]; o.blue_out = mid[7:0];
            end
        endcase
        o.alpha_out = px.alpha_in;
        return o;
    endfunction

    function automatic pix_in_t make_pixel(int rr, int gg, int bb, int aa);
        pix_in_t px;
        px.red_in = rr[7:0]; px.green_in = gg[7:0]; px.blue_in = bb[7:0];
        px.alpha_in = aa[7:0];
        return px;
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t px;
        int      mode;
        px = pix_in_t'($urandom);
        mode = $urandom_range(0, 9);
        // grays, ties and extremes show up more often than pure random
        if (mode == 0) begin
            px.green_in = px.red_in; px.blue_in = px.red_in;
        end else if (mode == 1) begin
            px.green_in = px.red_in;
        end else if (mode == 2) begin
            px.blue_in = px.green_in;
        end else if (mode == 3) begin
            px.red_in = 8'hff; px.blue_in = 8'h00;
        end
        return px;
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_idle <= $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else begin
                    s_data <= pending_pixels[0];
                    expected_pixels.push_back(saturate_pixel(pending_pixels[0], model_gain));
                    void'(pending_pixels.pop_front());
                    s_valid <= 1'b1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output monitor and ready generator
    always @(posedge aclk) begin
        pix_out_t want;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected output pixel %h", m_data);
                errors = errors + 1;
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.red_out !== want.red_out) begin
                    $error("red_out expected %0d actual %0d", want.red_out, m_data.red_out);
                    errors = errors + 1;
                end
                if (m_data.green_out !== want.green_out) begin
                    $error("green_out expected %0d actual %0d", want.green_out,
                           m_data.green_out);
                    errors = errors + 1;
                end
                if (m_data.blue_out !== want.blue_out) begin
                    $error("blue_out expected %0d actual %0d", want.blue_out, m_data.blue_out);
                    errors = errors + 1;
                end
                if (m_data.alpha_out !== want.alpha_out) begin
                    $error("alpha_out expected %0d actual %0d", want.alpha_out,
                           m_data.alpha_out);
                    errors = errors + 1;
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (snk_idle > 0) begin
            snk_idle <= snk_idle - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            snk_idle <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // timeout
    always @(posedge aclk) begin
        if (cycles > CycleLimit) begin
            $display("rgb_saturation_adjust_test NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || s_valid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_gain(logic [GainW-1:0] gain);
        cfg_data <= gain;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        model_gain = gain;
    endtask

    task automatic queue_directed();
        pending_pixels.push_back(make_pixel(0, 0, 0, 0));
        pending_pixels.push_back(make_pixel(255, 255, 255, 255));
        pending_pixels.push_back(make_pixel(128, 128, 128, 85));
        pending_pixels.push_back(make_pixel(255, 0, 0, 170));
        pending_pixels.push_back(make_pixel(0, 255, 0, 1));
        pending_pixels.push_back(make_pixel(0, 0, 255, 254));
        pending_pixels.push_back(make_pixel(255, 255, 0, 3));
        pending_pixels.push_back(make_pixel(0, 255, 255, 7));
        pending_pixels.push_back(make_pixel(255, 0, 255, 15));
        pending_pixels.push_back(make_pixel(200, 100, 150, 31));
        pending_pixels.push_back(make_pixel(255, 0, 1, 63));
        pending_pixels.push_back(make_pixel(1, 0, 0, 127));
        pending_pixels.push_back(make_pixel(100, 200, 200, 0));
        pending_pixels.push_back(make_pixel(10, 20, 30, 200));
    endtask

    initial begin
        logic [GainW-1:0] gains[6];
        gains = '{GainW'(0), GainW'(4095), GainW'(128), GainW'(512), GainW'(1), GainW'(256)};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // default gain first, then each setting
        queue_directed();
        repeat (200) pending_pixels.push_back(random_pixel());
        wait_drained();
        foreach (gains[i]) begin
            write_gain(gains[i]);
            queue_directed();
            if (i == 5) quiet = 1'b1;
            repeat (i == 5 ? 200 : 300) pending_pixels.push_back(random_pixel());
            wait_drained();
            write_gain(GainW'($urandom_range(0, 4095)));
            repeat (30) pending_pixels.push_back(random_pixel());
            wait_drained();
        end
        if (errors == 0) begin
            $display("rgb_saturation_adjust_test OK");
        end else begin
            $display("rgb_saturation_adjust_test NOT OK");
        end
        $finish;
    end
endmodule
